// ----- hdl/cpm_pkg.sv -----
package cpm_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_STEP_LENGTH  = 2'd2;

   localparam logic [15:0] FRAME_WIDTH_RESET  = 16'd16000;
   localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd16000;
   localparam logic [15:0] STEP_LENGTH_RESET  = 16'd16;

   // Pen home position, 20.0 and 25.0 in Q4
   localparam int PEN_X_RESET = 320;
   localparam int PEN_Y_RESET = 400;

   localparam int OFS_W  = 16;           // anchor offset, Q4
   localparam int SQ_W   = 2 * OFS_W;    // one squared offset
   localparam int LEN_W  = 21;           // cable length, Q8
   localparam int RAD_W  = 2 * LEN_W;    // radicand, padded to whole digit pairs
   localparam int REM_W  = LEN_W + 2;    // root remainder
   localparam int DIV_W  = OFS_W + 4;    // step length in Q8
   localparam int QUO_W  = 17;           // quotient bits that can be nonzero
   localparam int PRE_W  = LEN_W - QUO_W;
   localparam int STEPS_W = 16;

   localparam int ROOT_ITERS = LEN_W;
   localparam int DIV_ITERS  = QUO_W;
   localparam int ITER_W     = 5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_LEN_SAVE,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic take_req;
      logic sel_target;
      logic sq_x;
      logic sq_y;
      logic root_load;
      logic root_step;
      logic len_save;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

endpackage

// ----- hdl/cable_plotter_move_steps.sv -----
// One request is worked at a time, through two 21-step root extractions and a 17-step
// divide in each lane; the next request is taken once the result is loaded.
// The result sits in an output register, so a new request is taken while it waits.
// Reset (synchronous, active high) restores the frame registers and parks the pen
// at (20.0, 25.0); the block is ready for a request on the first cycle after reset.
module cable_plotter_move_steps #(
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // target_x[15:0], target_y[31:16]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // left_steps[15:0], left_lengthen[16],
                                    // right_steps[32:17], right_lengthen[33], zero
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import cpm_pkg::*;

   cmd_type cmd;

   // Controller sequences both cable lanes in lockstep: square the offsets,
   // extract the current length, then the target length, then divide the
   // length change by the step length.
   cpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Datapath: frame registers, pen position, left and right cable lanes,
   // and the result register.
   cpm_dpath #(
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ----- hdl/cpm_ctrl.sv -----
module cpm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output cpm_pkg::cmd_type cmd
);
   import cpm_pkg::*;

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              pass_ff, pass_in;
   logic              out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pass_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      cmd.sel_target = pass_ff;
      req_tready   = 1'b0;

      // drop the held result once it is taken
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_req = 1'b1;
               pass_in      = 1'b0;
               state_in     = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            cmd.sq_x = 1'b1;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            cmd.sq_y = 1'b1;
            state_in = ST_ROOT_LOAD;
         end
         ST_ROOT_LOAD: begin
            cmd.root_load = 1'b1;
            cnt_in        = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == ITER_W'(ROOT_ITERS - 1)) begin
               state_in = ST_LEN_SAVE;
            end
         end
         ST_LEN_SAVE: begin
            cmd.len_save = 1'b1;
            if (pass_ff) begin
               state_in = ST_DIV_LOAD;
            end else begin
               pass_in  = 1'b1;
               state_in = ST_SQ_X;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == ITER_W'(DIV_ITERS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

// ----- hdl/cpm_lane.sv -----
module cpm_lane (
   input  logic                         clock,
   input  cpm_pkg::cmd_type             cmd,
   input  logic [cpm_pkg::OFS_W-1:0]    anchor_x,
   input  logic [cpm_pkg::OFS_W-1:0]    anchor_y,
   input  logic [cpm_pkg::OFS_W-1:0]    point_x,
   input  logic [cpm_pkg::OFS_W-1:0]    point_y,
   input  logic [cpm_pkg::DIV_W-1:0]    divisor,
   output logic [cpm_pkg::STEPS_W-1:0]  steps,
   output logic                         lengthen
);
   import cpm_pkg::*;

   logic [OFS_W-1:0] dx, dy, mul_op;
   logic [SQ_W-1:0]  prod_ff, prod_in, sum_ff, sum_in;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in, rem_sh, trial;
   logic [LEN_W-1:0] root_ff, root_in, len_now_ff, len_now_in, len_new_ff, len_new_in;
   logic [LEN_W-1:0] mag;
   logic [DIV_W:0]   drem_ff, drem_in, dsh;
   logic [QUO_W-1:0] dnum_ff, dnum_in;
   logic             grow_ff, grow_in;
   logic [SQ_W:0]    sq_sum;

   always_comb begin
      dx     = (anchor_x >= point_x) ? anchor_x - point_x : point_x - anchor_x;
      dy     = (anchor_y >= point_y) ? anchor_y - point_y : point_y - anchor_y;
      mul_op = cmd.sq_y ? dy : dx;
      sq_sum = {1'b0, sum_ff} + {1'b0, prod_ff};
      rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
      mag    = (len_new_ff >= len_now_ff) ? len_new_ff - len_now_ff
                                          : len_now_ff - len_new_ff;
      dsh    = {drem_ff[DIV_W-1:0], dnum_ff[QUO_W-1]};

      prod_in    = prod_ff;
      sum_in     = sum_ff;
      rad_in     = rad_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      len_now_in = len_now_ff;
      len_new_in = len_new_ff;
      drem_in    = drem_ff;
      dnum_in    = dnum_ff;
      grow_in    = grow_ff;

      if (cmd.sq_x || cmd.sq_y) begin
         prod_in = mul_op * mul_op;
      end
      if (cmd.sq_y) begin
         sum_in = prod_ff;
      end
      // radicand is the squared length in Q16, so the root is in Q8; one root digit per step
      if (cmd.root_load) begin
         rad_in  = RAD_W'({sq_sum, 8'b0});
         rem_in  = '0;
         root_in = '0;
      end
      if (cmd.root_step) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[LEN_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[LEN_W-2:0], 1'b0};
         end
      end
      if (cmd.len_save) begin
         if (cmd.sel_target) begin
            len_new_in = root_ff;
         end else begin
            len_now_in = root_ff;
         end
      end
      // divisor is at least 16, so the top bits of the quotient are zero: preload them
      if (cmd.div_load) begin
         grow_in = (len_new_ff > len_now_ff);
         drem_in = (DIV_W + 1)'(mag[LEN_W-1 -: PRE_W]);
         dnum_in = mag[QUO_W-1:0];
      end
      if (cmd.div_step) begin
         if (dsh >= {1'b0, divisor}) begin
            drem_in = dsh - {1'b0, divisor};
            dnum_in = {dnum_ff[QUO_W-2:0], 1'b1};
         end else begin
            drem_in = dsh;
            dnum_in = {dnum_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      rad_ff     <= rad_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      len_now_ff <= len_now_in;
      len_new_ff <= len_new_in;
      drem_ff    <= drem_in;
      dnum_ff    <= dnum_in;
      grow_ff    <= grow_in;
   end

   // saturate
   assign steps    = dnum_ff[QUO_W-1] ? {STEPS_W{1'b1}} : dnum_ff[STEPS_W-1:0];
   assign lengthen = grow_ff;

endmodule

// ----- hdl/cpm_dpath.sv -----
module cpm_dpath #(
   parameter int COORD_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  cpm_pkg::cmd_type cmd,
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [15:0]      csr_wdata,
   input  logic [31:0]      req_tdata,
   output logic [39:0]      rsp_tdata
);
   import cpm_pkg::*;

   localparam int PEN_W = (COORD_BITS < OFS_W) ? COORD_BITS : OFS_W;

   logic [15:0]      frame_width_ff, frame_height_ff, step_length_ff;
   logic [PEN_W-1:0] pen_x_ff, pen_y_ff, tgt_x_ff, tgt_y_ff;
   logic [OFS_W-1:0] point_x, point_y;
   logic [15:0]      step_eff;
   logic [DIV_W-1:0] divisor;
   logic [STEPS_W-1:0] l_steps, r_steps;
   logic             l_grow, r_grow;
   logic [39:0]      out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         step_length_ff  <= STEP_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            CSR_STEP_LENGTH:  step_length_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pen moves to the target once both lengths are known
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= PEN_W'(PEN_X_RESET);
         pen_y_ff <= PEN_W'(PEN_Y_RESET);
      end else if (cmd.div_load) begin
         pen_x_ff <= tgt_x_ff;
         pen_y_ff <= tgt_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         tgt_x_ff <= req_tdata[PEN_W-1:0];
         tgt_y_ff <= req_tdata[16 +: PEN_W];
      end
      if (cmd.out_load) begin
         out_ff <= {6'b0, r_grow, r_steps, l_grow, l_steps};
      end
   end

   assign point_x  = cmd.sel_target ? OFS_W'(tgt_x_ff) : OFS_W'(pen_x_ff);
   assign point_y  = cmd.sel_target ? OFS_W'(tgt_y_ff) : OFS_W'(pen_y_ff);
   assign step_eff = (step_length_ff == 16'd0) ? 16'd1 : step_length_ff;
   assign divisor  = {step_eff, 4'b0};

   cpm_lane u_left (
      .clock    (clock),
      .cmd      (cmd),
      .anchor_x ('0),
      .anchor_y (frame_height_ff),
      .point_x  (point_x),
      .point_y  (point_y),
      .divisor  (divisor),
      .steps    (l_steps),
      .lengthen (l_grow)
   );

   cpm_lane u_right (
      .clock    (clock),
      .cmd      (cmd),
      .anchor_x (frame_width_ff),
      .anchor_y (frame_height_ff),
      .point_x  (point_x),
      .point_y  (point_y),
      .divisor  (divisor),
      .steps    (r_steps),
      .lengthen (r_grow)
   );

   assign rsp_tdata = out_ff;

endmodule

// ----- tb/cable_plotter_move_steps_tb.sv -----
module cable_plotter_move_steps_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cpm_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 8;
   localparam int QUIET_LIMIT    = 4000;  // cycles without any handshake before giving up
   localparam int IDLE_SETTLE    = 4;     // extra cycles after the last result before a CSR write
   localparam int SETTLE_CYCLES  = 80;    // a little past the request-to-result latency
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PHASES  = 4;
   localparam int PHASE_REQUESTS = 95;
   localparam logic [1:0]  CSR_SPARE = 2'd3;      // no register lives at this index
   localparam logic [15:0] STEPS_SAT = 16'hFFFF;

   typedef struct packed {
      logic [15:0] left_steps;
      logic        left_lengthen;
      logic [15:0] right_steps;
      logic        right_lengthen;
   } move_steps_type;

   typedef enum int {PT_ANY, PT_NEAR, PT_FRAME, PT_STAY} target_kind_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // target_x[15:0], target_y[31:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // left_steps[15:0], left_lengthen[16], right_steps[32:17],
                              // right_lengthen[33], zero pad[39:34]
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   // Shadow of the frame registers and the pen, advanced as requests are accepted
   logic [15:0] frame_w;
   logic [15:0] frame_h;
   logic [15:0] step_len;
   logic [15:0] pen_x;
   logic [15:0] pen_y;

   move_steps_type planned_moves[$];
   int          fail_count;
   bit          idle_on;

   cable_plotter_move_steps #(
      .COORD_BITS(16)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   function automatic void log_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Digit-by-digit integer square root, floor
   function automatic logic [63:0] floor_sqrt(input logic [63:0] radicand);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] probe;
      rest  = radicand;
      root  = '0;
      probe = 64'd1 << 62;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Cable length in Q8 from anchor (anchor_x, frame_h) to point (px, py)
   function automatic logic [63:0] cable_q8(input logic [15:0] anchor_x,
                                            input logic [15:0] px, input logic [15:0] py);
      logic [63:0] dx;
      logic [63:0] dy;
      dx = (anchor_x >= px) ? 64'(anchor_x - px) : 64'(px - anchor_x);
      dy = (frame_h >= py) ? 64'(frame_h - py) : 64'(py - frame_h);
      return floor_sqrt((dx * dx + dy * dy) << 8);
   endfunction

   function automatic void motor_steps(input logic [63:0] from_len, input logic [63:0] to_len,
                                       output logic [15:0] steps, output logic grow);
      logic [63:0] per_step;
      logic [63:0] change;
      logic [63:0] count;
      // a zero step length behaves as one Q4 unit
      per_step = (step_len == 16'd0) ? 64'd16 : (64'(step_len) << 4);
      change   = (to_len >= from_len) ? to_len - from_len : from_len - to_len;
      count    = change / per_step;
      steps    = (count > 64'(STEPS_SAT)) ? STEPS_SAT : count[15:0];
      grow     = (to_len > from_len);
   endfunction

   // Work out the motor move for one target and park the pen there
   function automatic move_steps_type plan_move(input logic [15:0] tx, input logic [15:0] ty);
      move_steps_type m;
      logic [15:0] ls, rs;
      logic        lg, rg;
      motor_steps(cable_q8(16'd0, pen_x, pen_y), cable_q8(16'd0, tx, ty), ls, lg);
      motor_steps(cable_q8(frame_w, pen_x, pen_y), cable_q8(frame_w, tx, ty), rs, rg);
      m.left_steps     = ls;
      m.left_lengthen  = lg;
      m.right_steps    = rs;
      m.right_lengthen = rg;
      pen_x = tx;
      pen_y = ty;
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------

   // Offer one target point; hold it until accepted, then queue its expected move.
   // Leave req_tvalid high on return so back-to-back requests need no re-raise.
   task automatic send_target(input logic [15:0] tx, input logic [15:0] ty);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ty, tx};
      do @(posedge clock); while (!req_tready);
      planned_moves.push_back(plan_move(tx, ty));
   endtask

   // Drop the request line and hold off until every queued move has come back
   task automatic wait_until_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (planned_moves.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] addr, input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      case (addr)
         CSR_FRAME_WIDTH:  frame_w  = value;
         CSR_FRAME_HEIGHT: frame_h  = value;
         CSR_STEP_LENGTH:  step_len = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_frame(input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] sl);
      wait_until_idle();
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      write_csr(CSR_STEP_LENGTH, sl);
   endtask

   function automatic logic [15:0] pick_extent();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(1, 65535));
         1:       return 16'($urandom_range(8000, 24000));
         2:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1;
         default: return 16'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic logic [15:0] pick_step();
      case ($urandom_range(0, 5))
         0:       return 16'($urandom_range(1, 65535));
         1:       return 16'd1;
         default: return 16'($urandom_range(1, 32));
      endcase
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return v;
   endfunction

   // Pick a target: anywhere, a short hop from the pen, inside the frame, or no move
   task automatic pick_target(output logic [15:0] tx, output logic [15:0] ty);
      target_kind_type kind;
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 3) kind = PT_ANY;
      else if (sel < 6) kind = PT_NEAR;
      else if (sel < 9) kind = PT_FRAME;
      else kind = PT_STAY;
      case (kind)
         PT_ANY: begin
            tx = 16'($urandom);
            ty = 16'($urandom);
         end
         PT_NEAR: begin
            tx = 16'(clamp_coord(int'(pen_x) + int'($urandom_range(0, 128)) - 64));
            ty = 16'(clamp_coord(int'(pen_y) + int'($urandom_range(0, 128)) - 64));
         end
         PT_FRAME: begin
            tx = 16'($urandom_range(0, frame_w));
            ty = 16'($urandom_range(0, frame_h));
         end
         default: begin
            tx = pen_x;
            ty = pen_y;
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls on tready, and a check of every accepted result
   // ---------------------------------------------------------------------

   initial begin : drive_rsp_ready
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall == 0 && idle_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_moves
      move_steps_type want;
      move_steps_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.left_steps     = rsp_tdata[15:0];
         got.left_lengthen  = rsp_tdata[16];
         got.right_steps    = rsp_tdata[32:17];
         got.right_lengthen = rsp_tdata[33];
         if (planned_moves.size() == 0) begin
            log_failure($sformatf("unexpected result: L %0d/%b R %0d/%b",
                                  got.left_steps, got.left_lengthen,
                                  got.right_steps, got.right_lengthen));
         end else begin
            want = planned_moves.pop_front();
            if (got !== want)
               log_failure($sformatf("move mismatch: exp L %0d/%b R %0d/%b, got L %0d/%b R %0d/%b",
                                     want.left_steps, want.left_lengthen,
                                     want.right_steps, want.right_lengthen,
                                     got.left_steps, got.left_lengthen,
                                     got.right_steps, got.right_lengthen));
         end
      end
   end

   // Give up when nothing moves on any port for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (reset === 1'b0);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no handshake for %0d cycles, %0d moves pending",
               QUIET_LIMIT, planned_moves.size());
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset frame: corners of the coordinate space, anchors, no-move and bit patterns
   task automatic test_directed_moves();
      send_target(16'd320, 16'd400);       // home again: no movement
      send_target(16'd0, 16'd0);
      send_target(16'hFFFF, 16'hFFFF);
      send_target(16'hFFFF, 16'd0);
      send_target(16'd0, 16'hFFFF);
      send_target(16'd0, 16'hFFFF);        // same point twice
      send_target(16'd0, 16'd16000);       // onto the left anchor
      send_target(16'd16000, 16'd16000);   // onto the right anchor
      send_target(16'd16000, 16'hFFFF);    // above the anchor line
      send_target(16'd40000, 16'd20000);   // past the right anchor
      send_target(16'd16001, 16'd16000);
      send_target(16'd16000, 16'd16000);   // one Q4 unit back
      send_target(16'h5555, 16'hAAAA);
      send_target(16'hAAAA, 16'h5555);
   endtask

   // Extreme register settings, including a zero step length and the spare index
   task automatic test_frame_extremes();
      wait_until_idle();
      write_csr(CSR_SPARE, 16'hFFFF);      // must not disturb the frame
      send_target(16'd0, 16'd0);
      send_target(16'hFFFF, 16'hFFFF);
      // widest frame, finest step: long moves saturate the step count
      load_frame(16'hFFFF, 16'hFFFF, 16'd1);
      send_target(16'd0, 16'd0);
      send_target(16'hFFFF, 16'd0);
      send_target(16'd0, 16'hFFFF);
      // tiny frame, zero step length
      load_frame(16'd1, 16'd1, 16'd0);
      send_target(16'd0, 16'd0);
      send_target(16'hFFFF, 16'hFFFF);
      send_target(16'd1, 16'd1);
      send_target(16'd1, 16'd1);
      // coarsest step: most moves round down to zero steps
      load_frame(16'hFFFF, 16'd1, 16'hFFFF);
      send_target(16'd0, 16'hFFFF);
      send_target(16'hFFFF, 16'd0);
   endtask

   // Let the pipeline drain fully mid-stream, then resume
   task automatic test_pause_for_results();
      logic [15:0] tx, ty;
      load_frame(FRAME_WIDTH_RESET, FRAME_HEIGHT_RESET, STEP_LENGTH_RESET);
      repeat (2) begin
         repeat (5) begin
            pick_target(tx, ty);
            send_target(tx, ty);
         end
         wait_until_idle();
      end
   endtask

   // Random frames and targets; the final phase runs with no idling on either side
   task automatic test_random_moves();
      logic [15:0] tx, ty;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase < RANDOM_PHASES - 1);
         if (phase == 2) load_frame(pick_extent(), pick_extent(), 16'd1);
         else load_frame(pick_extent(), pick_extent(), pick_step());
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            pick_target(tx, ty);
            send_target(tx, ty);
            if ($urandom_range(0, 39) == 0) wait_until_idle();
         end
      end
   endtask

   initial begin : main
      fail_count = 0;
      idle_on    = 1'b1;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = CSR_FRAME_WIDTH;
      csr_wdata  = '0;
      frame_w    = FRAME_WIDTH_RESET;
      frame_h    = FRAME_HEIGHT_RESET;
      step_len   = STEP_LENGTH_RESET;
      pen_x      = 16'(PEN_X_RESET);
      pen_y      = 16'(PEN_Y_RESET);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_moves();
      test_frame_extremes();
      test_pause_for_results();
      test_random_moves();

      // Drain, then give the block time to show any stray result
      wait_until_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (planned_moves.size() != 0)
         log_failure($sformatf("%0d moves never came back", planned_moves.size()));

      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
